>>> hw/rtl/positional_list_engine_defines.svh
// Assertion macros shared by the positional list engine RTL.
// No dependencies; define NO_ASSERTIONS to compile the checks away.
`ifndef POSITIONAL_LIST_ENGINE_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// prop must hold at every clock edge outside reset
`define PLE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// cond must never be true outside reset
`define PLE_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define PLE_ASSERT(lbl, clk, rst_n, prop, msg)
`define PLE_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

>>> hw/rtl/ple_pkg.sv
// Package for the positional list engine: field widths, codes, transaction types.
// No dependencies.
package ple_pkg;

  localparam int unsigned OP_W  = 2;
  localparam int unsigned POS_W = 7;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned LEN_W = 7;
  localparam int unsigned ST_W  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_DUMP   = 2'd2
  } opcode_e;

  typedef enum logic [ST_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [OP_W-1:0]         opcode;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] element;
    logic [LEN_W-1:0]        length;
    logic [ST_W-1:0]         status;
    logic                    last;
  } out_item_t;

endpackage

>>> hw/rtl/ple_mem.sv
// Element store: one write port, one read port, registered read data.
// Depends on ple_pkg for the element width.
module ple_mem #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AddrW-1:0]            waddr_i,
  input  logic [ple_pkg::VAL_W-1:0]   wdata_i,
  input  logic                        re_i,
  input  logic [AddrW-1:0]            raddr_i,
  output logic [ple_pkg::VAL_W-1:0]   rdata_o
);

  logic [ple_pkg::VAL_W-1:0] mem_q [Depth];
  logic [ple_pkg::VAL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/ple_ctrl.sv
// Sequencer for the positional list engine: decode, shift passes, dump, result register.
// Depends on ple_pkg and positional_list_engine_defines.svh; drives ple_mem.
`include "positional_list_engine_defines.svh"

module ple_ctrl #(
  parameter int unsigned Capacity = 64,
  parameter int unsigned AddrW    = 6
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  ple_pkg::in_item_t         in_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output ple_pkg::out_item_t        out_o,
  output logic                      mem_we_o,
  output logic [AddrW-1:0]          mem_waddr_o,
  output logic [ple_pkg::VAL_W-1:0] mem_wdata_o,
  output logic                      mem_re_o,
  output logic [AddrW-1:0]          mem_raddr_o,
  input  logic [ple_pkg::VAL_W-1:0] mem_rdata_i
);

  localparam int unsigned LenW = $clog2(Capacity + 1);
  localparam logic [LenW-1:0] CapLen = LenW'(Capacity);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SHIFT = 5'b00010,
    S_LAST  = 5'b00100,
    S_PUT   = 5'b01000,
    S_DUMP  = 5'b10000
  } state_e;

  state_e                    state_q, state_d;
  logic [LenW-1:0]           len_q, len_d;
  logic [AddrW-1:0]          ptr_q, ptr_d;
  logic [AddrW-1:0]          src_q, src_d;
  logic [AddrW-1:0]          end_q, end_d;
  logic [AddrW-1:0]          slot_q, slot_d;
  logic [ple_pkg::VAL_W-1:0] val_q, val_d;
  logic                      ins_q, ins_d;
  logic                      wr_pend_q, wr_pend_d;
  logic                      rd_pend_q, rd_pend_d;
  logic                      out_valid_q, out_valid_d;
  ple_pkg::out_item_t        out_q, out_d;

  logic                      out_free;
  logic                      accept;
  logic                      load;
  logic [ple_pkg::POS_W-1:0] pos;
  logic [ple_pkg::POS_W-1:0] len_ext;
  logic [ple_pkg::POS_W-1:0] ins_slot;
  logic [ple_pkg::POS_W-1:0] del_slot;
  logic [LenW-1:0]           len_inc;
  logic [LenW-1:0]           len_dec;
  logic [AddrW-1:0]          shift_waddr;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == S_IDLE) && out_free);
  assign accept     = in_valid_i && !in_stall_o;

  assign pos     = in_i.position;
  assign len_ext = ple_pkg::POS_W'(len_q);
  assign len_inc = len_q + LenW'(1);
  assign len_dec = len_q - LenW'(1);

  // target cells; positions at or below one mean head, past length mean tail
  always_comb begin
    if ((len_q == '0) || (pos > len_ext)) begin
      ins_slot = len_ext;
    end else if (pos <= ple_pkg::POS_W'(1)) begin
      ins_slot = '0;
    end else begin
      ins_slot = pos - ple_pkg::POS_W'(1);
    end
    if ((len_q == LenW'(1)) || (pos > len_ext)) begin
      del_slot = len_ext - ple_pkg::POS_W'(1);
    end else if (pos <= ple_pkg::POS_W'(1)) begin
      del_slot = '0;
    end else begin
      del_slot = pos - ple_pkg::POS_W'(1);
    end
  end

  // insert moves cells up, delete moves them down
  assign shift_waddr = ins_q ? (src_q + AddrW'(1)) : (src_q - AddrW'(1));

  always_comb begin
    state_d   = state_q;
    len_d     = len_q;
    ptr_d     = ptr_q;
    src_d     = src_q;
    end_d     = end_q;
    slot_d    = slot_q;
    val_d     = val_q;
    ins_d     = ins_q;
    wr_pend_d = wr_pend_q;
    rd_pend_d = rd_pend_q;
    out_d     = out_q;
    load      = 1'b0;

    mem_we_o    = 1'b0;
    mem_waddr_o = shift_waddr;
    mem_wdata_o = mem_rdata_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = ptr_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (ple_pkg::opcode_e'(in_i.opcode))
            ple_pkg::OP_INSERT: begin
              load = 1'b1;
              if (len_q == CapLen) begin
                out_d = '{element: '0, length: ple_pkg::LEN_W'(len_q),
                          status: ple_pkg::ST_FULL, last: 1'b1};
              end else begin
                len_d = len_inc;
                if (ins_slot == len_ext) begin
                  // append: no cells move
                  mem_we_o    = 1'b1;
                  mem_waddr_o = AddrW'(len_q);
                  mem_wdata_o = in_i.value;
                  out_d = '{element: '0, length: ple_pkg::LEN_W'(len_inc),
                            status: ple_pkg::ST_DONE, last: 1'b1};
                end else begin
                  load      = 1'b0;
                  ins_d     = 1'b1;
                  val_d     = in_i.value;
                  slot_d    = AddrW'(ins_slot);
                  ptr_d     = AddrW'(len_dec);
                  end_d     = AddrW'(ins_slot);
                  wr_pend_d = 1'b0;
                  state_d   = S_SHIFT;
                end
              end
            end
            ple_pkg::OP_DELETE: begin
              load = 1'b1;
              if (len_q == '0) begin
                out_d = '{element: '0, length: '0,
                          status: ple_pkg::ST_EMPTY, last: 1'b1};
              end else begin
                len_d = len_dec;
                if (del_slot == (len_ext - ple_pkg::POS_W'(1))) begin
                  // tail removal: no cells move
                  out_d = '{element: '0, length: ple_pkg::LEN_W'(len_dec),
                            status: ple_pkg::ST_DONE, last: 1'b1};
                end else begin
                  load      = 1'b0;
                  ins_d     = 1'b0;
                  ptr_d     = AddrW'(del_slot) + AddrW'(1);
                  end_d     = AddrW'(len_dec);
                  wr_pend_d = 1'b0;
                  state_d   = S_SHIFT;
                end
              end
            end
            ple_pkg::OP_DUMP: begin
              if (len_q == '0) begin
                load  = 1'b1;
                out_d = '{element: '0, length: '0,
                          status: ple_pkg::ST_EMPTY, last: 1'b1};
              end else begin
                ptr_d     = '0;
                end_d     = AddrW'(len_dec);
                rd_pend_d = 1'b0;
                state_d   = S_DUMP;
              end
            end
            default: begin
              load  = 1'b1;
              out_d = '{element: '0, length: ple_pkg::LEN_W'(len_q),
                        status: ple_pkg::ST_DONE, last: 1'b1};
            end
          endcase
        end
      end

      S_SHIFT: begin
        // read one cell ahead, write the previous one back shifted
        mem_re_o  = 1'b1;
        mem_we_o  = wr_pend_q;
        src_d     = ptr_q;
        wr_pend_d = 1'b1;
        if (ptr_q == end_q) begin
          state_d = S_LAST;
        end else begin
          ptr_d = ins_q ? (ptr_q - AddrW'(1)) : (ptr_q + AddrW'(1));
        end
      end

      S_LAST: begin
        mem_we_o  = wr_pend_q;
        wr_pend_d = 1'b0;
        if (ins_q) begin
          state_d = S_PUT;
        end else begin
          load    = 1'b1;
          out_d   = '{element: '0, length: ple_pkg::LEN_W'(len_q),
                      status: ple_pkg::ST_DONE, last: 1'b1};
          state_d = S_IDLE;
        end
      end

      S_PUT: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = slot_q;
        mem_wdata_o = val_q;
        load        = 1'b1;
        out_d       = '{element: '0, length: ple_pkg::LEN_W'(len_q),
                        status: ple_pkg::ST_DONE, last: 1'b1};
        state_d     = S_IDLE;
      end

      S_DUMP: begin
        if (rd_pend_q) begin
          load      = 1'b1;
          rd_pend_d = 1'b0;
          out_d     = '{element: mem_rdata_i, length: ple_pkg::LEN_W'(len_q),
                        status: ple_pkg::ST_DONE, last: (src_q == end_q)};
          if (src_q == end_q) begin
            state_d = S_IDLE;
          end
        end else if (out_free) begin
          // read only when the result register is free by the time data lands
          mem_re_o  = 1'b1;
          src_d     = ptr_q;
          ptr_d     = ptr_q + AddrW'(1);
          rd_pend_d = 1'b1;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      wr_pend_q   <= 1'b0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      wr_pend_q   <= wr_pend_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q  <= ptr_d;
    src_q  <= src_d;
    end_q  <= end_d;
    slot_q <= slot_d;
    val_q  <= val_d;
    ins_q  <= ins_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `PLE_ASSERT(a_len_bound, clk_i, rst_ni, len_q <= CapLen, "list length above capacity")
  `PLE_NEVER(a_idle_no_write, clk_i, rst_ni, (state_q == S_IDLE) && mem_we_o && !accept, "idle write")
  `PLE_NEVER(a_no_overwrite, clk_i, rst_ni, load && out_valid_q && out_stall_i, "held result overwritten")
  `PLE_ASSERT(a_wr_pend_ctx, clk_i, rst_ni, wr_pend_q |-> ((state_q == S_SHIFT) || (state_q == S_LAST)), "pending shift write outside shift pass")
  `PLE_ASSERT(a_rd_pend_ctx, clk_i, rst_ni, rd_pend_q |-> (state_q == S_DUMP), "pending dump read outside dump")

endmodule

>>> hw/rtl/positional_list_engine.sv
// Top level of the positional list engine: an ordered list of signed 32-bit values.
// Depends on ple_pkg; instantiates ple_ctrl and ple_mem.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_i) carries one command per
//   transaction: insert at a 1-based position, delete at a position, or dump.
//   Output channel (out_valid_o / out_stall_i / out_o) returns one result per
//   insert or delete and one result per element for a dump (last marks the end).
//   Elements live in one single-port-write, registered-read RAM; a command that
//   lands inside the list moves the cells behind it one per cycle.
// Sequencing:
//   Append, tail delete, full, empty: result valid in the cycle after accept.
//   Shifting insert: S_SHIFT, S_LAST, then S_PUT stores the value and the result;
//   shifting delete: S_SHIFT, then S_LAST. Dump: per element a RAM read, then the
//   result register; the next read waits until that register is free.
// Reset clears the length to zero; RAM contents are left as they are and are
// never read before being written. A stalled result stays in the output
// register; a new command is taken once that register is free or draining.
module positional_list_engine #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ple_pkg::in_item_t   in_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ple_pkg::out_item_t  out_o
);

  localparam int unsigned AddrW = $clog2(CAPACITY);

  // RAM port wiring between sequencer and element store
  logic                      mem_we;
  logic [AddrW-1:0]          mem_waddr;
  logic [ple_pkg::VAL_W-1:0] mem_wdata;
  logic                      mem_re;
  logic [AddrW-1:0]          mem_raddr;
  logic [ple_pkg::VAL_W-1:0] mem_rdata;

  ple_ctrl #(
    .Capacity (CAPACITY),
    .AddrW    (AddrW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // element cells, index 0 is the head of the list
  ple_mem #(
    .Depth (CAPACITY),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule
